// File: sv/indexed_list_insert_delete_macros.svh
// assertion macros for the indexed list checker
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ILID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("indexed list check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define ILID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("indexed list check failed");

`endif

// File: sv/ilid_pkg.sv
// types and codes shared by the indexed list block
`default_nettype none

package ilid_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 2;

  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } ctrl_t;

endpackage

`default_nettype wire

// File: sv/ilid_req_if.sv
// request channel: one list operation per word
`default_nettype none

interface ilid_req_if #(
  parameter int unsigned IdxW = 7
);
  logic                        valid;
  logic                        ready;
  logic [ilid_pkg::OpW-1:0]    op;
  ilid_pkg::word_t             value;
  logic [IdxW-1:0]             index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

`default_nettype wire

// File: sv/ilid_rsp_if.sv
// response channel: one result word per operation
`default_nettype none

interface ilid_rsp_if #(
  parameter int unsigned IdxW = 7
);
  logic                        valid;
  logic                        ready;
  ilid_pkg::word_t             read_value;
  logic [ilid_pkg::StW-1:0]    status;
  logic [IdxW-1:0]             count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

// File: sv/ilid_cell.sv
// one list cell: holds one element, shifts to or from its neighbours
`default_nettype none

module ilid_cell #(
  parameter int unsigned IdxW    = 7,
  parameter int unsigned CellIdx = 0
) (
  input  wire logic            clk_i,
  input  wire ilid_pkg::ctrl_t ctrl_i,
  input  wire logic [IdxW-1:0] pos_i,
  input  wire ilid_pkg::word_t value_i,
  input  wire ilid_pkg::word_t left_i,
  input  wire ilid_pkg::word_t right_i,
  output ilid_pkg::word_t      data_o,
  output ilid_pkg::word_t      rd_o
);

  localparam logic [IdxW-1:0] MyPos = IdxW'(CellIdx);

  ilid_pkg::word_t data_d, data_q;
  logic            above, at;

  assign above = MyPos > pos_i;
  assign at    = MyPos == pos_i;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (at) begin
        data_d = value_i;
      end
    end else if (ctrl_i.del) begin
      if (above || at) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = at ? data_q : '0;

endmodule

`default_nettype wire

// File: sv/indexed_list_insert_delete.sv
// top level: fixed-capacity ordered list built as a row of shifting cells
//
//   port    dir  carries                       accepted when
//   req_i   in   op, value, index              valid & ready
//   rsp_o   out  read_value, status, count     valid & ready
//
// on an accepted insert or delete all affected cells shift together
// a new word is taken each cycle while the result register is empty or being drained
// get reads through an or-tree over the cells into the result register
// reset empties the list; cell contents are not cleared
// a stalled result holds the request side until it is taken
`default_nettype none

module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ilid_req_if.sink   req_i,
  ilid_rsp_if.source rsp_o
);

  localparam int unsigned     IdxW   = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] CapVal = IdxW'(CAPACITY);

  logic [IdxW-1:0]         cnt_d, cnt_q;
  logic                    accept, full, get_ok;
  ilid_pkg::ctrl_t         ctrl;
  logic [IdxW-1:0]         pos;
  ilid_pkg::status_e       st;
  ilid_pkg::word_t         cell_q [CAPACITY];
  ilid_pkg::word_t         rd_w   [CAPACITY];
  ilid_pkg::word_t         rd_any;

  logic                    valid_q;
  ilid_pkg::word_t         rdval_q;
  logic [ilid_pkg::StW-1:0] status_q;
  logic [IdxW-1:0]         count_q;

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = cnt_q == CapVal;

  // decode
  always_comb begin
    ctrl   = '0;
    st     = ilid_pkg::ST_OK;
    get_ok = 1'b0;
    cnt_d  = cnt_q;
    pos    = req_i.index;
    case (ilid_pkg::op_e'(req_i.op))
      ilid_pkg::OP_APPEND: begin
        pos = cnt_q;
        if (full) begin
          st = ilid_pkg::ST_FULL;
        end else begin
          ctrl.ins = accept;
          cnt_d    = cnt_q + IdxW'(1);
        end
      end
      ilid_pkg::OP_INSERT: begin
        if (req_i.index > cnt_q) begin
          st = ilid_pkg::ST_RANGE;
        end else if (full) begin
          st = ilid_pkg::ST_FULL;
        end else begin
          ctrl.ins = accept;
          cnt_d    = cnt_q + IdxW'(1);
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (req_i.index >= cnt_q) begin
          st = ilid_pkg::ST_RANGE;
        end else begin
          ctrl.del = accept;
          cnt_d    = cnt_q - IdxW'(1);
        end
      end
      ilid_pkg::OP_GET: begin
        if (req_i.index >= cnt_q) begin
          st = ilid_pkg::ST_RANGE;
        end else begin
          get_ok = 1'b1;
        end
      end
      ilid_pkg::OP_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    ilid_pkg::word_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[k+1];
    end

    ilid_cell #(
      .IdxW    (IdxW),
      .CellIdx (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos),
      .value_i (req_i.value),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_q[k]),
      .rd_o    (rd_w[k])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd_w[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q   <= cnt_d;
        valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdval_q  <= get_ok ? rd_any : '0;
      status_q <= st;
      count_q  <= cnt_d;
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.read_value = rdval_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.count      = count_q;

endmodule

`default_nettype wire

// File: sv/ilid_chk.sv
// port-level checks for the indexed list, bound to the top level
`default_nettype none

`include "indexed_list_insert_delete_macros.svh"

module ilid_chk #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned IdxW     = 7
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     req_valid_i,
  input wire logic                     req_ready_i,
  input wire logic [ilid_pkg::OpW-1:0] req_op_i,
  input wire logic                     rsp_valid_i,
  input wire logic                     rsp_ready_i,
  input wire ilid_pkg::word_t          rsp_read_value_i,
  input wire logic [ilid_pkg::StW-1:0] rsp_status_i,
  input wire logic [IdxW-1:0]          rsp_count_i
);

  localparam logic [IdxW-1:0] CapVal = IdxW'(CAPACITY);

  logic req_acc, clear_acc, rsp_stall, rsp_err, rsp_full, rsp_empty_ok;
  logic [ilid_pkg::WordW+ilid_pkg::StW+IdxW-1:0] rsp_word;

  assign req_acc      = req_valid_i && req_ready_i;
  assign clear_acc    = req_acc && (req_op_i == ilid_pkg::OP_CLEAR);
  assign rsp_stall    = rsp_valid_i && !rsp_ready_i;
  assign rsp_err      = rsp_valid_i && (rsp_status_i != ilid_pkg::ST_OK);
  assign rsp_full     = rsp_valid_i && (rsp_status_i == ilid_pkg::ST_FULL);
  assign rsp_empty_ok = rsp_valid_i && (rsp_count_i == '0) && (rsp_status_i == ilid_pkg::ST_OK);
  assign rsp_word     = {rsp_read_value_i, rsp_status_i, rsp_count_i};

  `ILID_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid_i && $stable(rsp_word))
  `ILID_ASSERT_NOW(a_count_cap, rsp_valid_i, rsp_count_i <= CapVal)
  `ILID_ASSERT_NOW(a_err_no_data, rsp_err, rsp_read_value_i == '0)
  `ILID_ASSERT_NOW(a_full_at_cap, rsp_full, rsp_count_i == CapVal)
  `ILID_ASSERT_NEXT(a_clear, clear_acc, rsp_empty_ok)

endmodule

bind indexed_list_insert_delete ilid_chk #(
  .CAPACITY (CAPACITY),
  .IdxW     (IdxW)
) u_ilid_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_op_i         (req_i.op),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_read_value_i (rsp_o.read_value),
  .rsp_status_i     (rsp_o.status),
  .rsp_count_i      (rsp_o.count)
);

`default_nettype wire

// File: tb/sv/ilid_list_checker.sv
// checker for the indexed list: predicts every result word and compares it
`default_nettype none

module ilid_list_checker #(
  parameter int Cap = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ilid_req_if       req_w,
  ilid_rsp_if       rsp_w,
  output int        mismatches_o,
  output int        pending_o,
  output int        list_len_o,
  output int        checked_o,
  output int        full_seen_o,
  output int        range_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ilid_pkg::word_t          rd;
    logic [ilid_pkg::StW-1:0] st;
    logic [6:0]               cnt;
  } list_result_t;

  ilid_pkg::word_t cells [Cap];
  int              len;
  list_result_t    expected_q [$];
  int              mism;
  int              checked;
  int              full_seen;
  int              range_seen;

  function automatic list_result_t apply_list_op(logic [ilid_pkg::OpW-1:0] op,
                                                 ilid_pkg::word_t val,
                                                 logic [6:0] idx);
    list_result_t r;
    int k;
    r.rd = '0;
    r.st = ilid_pkg::ST_OK;
    case (op)
      ilid_pkg::OP_APPEND: begin
        if (len >= Cap) begin
          r.st = ilid_pkg::ST_FULL;
        end else begin
          cells[len] = val;
          len++;
        end
      end
      ilid_pkg::OP_INSERT: begin
        if (int'(idx) > len) begin
          r.st = ilid_pkg::ST_RANGE;
        end else if (len >= Cap) begin
          r.st = ilid_pkg::ST_FULL;
        end else begin
          for (k = len; k > int'(idx); k--) cells[k] = cells[k-1];
          cells[idx] = val;
          len++;
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (int'(idx) >= len) begin
          r.st = ilid_pkg::ST_RANGE;
        end else begin
          for (k = int'(idx); k + 1 < len; k++) cells[k] = cells[k+1];
          len--;
        end
      end
      ilid_pkg::OP_GET: begin
        if (int'(idx) >= len) r.st = ilid_pkg::ST_RANGE;
        else r.rd = cells[idx];
      end
      ilid_pkg::OP_CLEAR: len = 0;
      default: ;
    endcase
    r.cnt = len[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      len = 0;
      mism = 0;
      checked = 0;
      full_seen = 0;
      range_seen = 0;
      expected_q.delete();
      mismatches_o <= 0;
      pending_o <= 0;
      list_len_o <= 0;
      checked_o <= 0;
      full_seen_o <= 0;
      range_seen_o <= 0;
    end else begin
      if (req_w.valid && req_w.ready) begin
        expected_q.push_back(apply_list_op(req_w.op, req_w.value, req_w.index));
      end
      if (rsp_w.valid && rsp_w.ready) begin
        got.rd = rsp_w.read_value;
        got.st = rsp_w.status;
        got.cnt = rsp_w.count;
        if (expected_q.size() == 0) begin
          if (mism < 10) begin
            $display("[%0t] unexpected result word: read_value=%0d status=%0d count=%0d",
                     $realtime, got.rd, got.st, got.cnt);
          end
          mism++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.st == ilid_pkg::ST_FULL) full_seen++;
          if (want.st == ilid_pkg::ST_RANGE) range_seen++;
          if (got.rd !== want.rd || got.st !== want.st || got.cnt !== want.cnt) begin
            if (mism < 10) begin
              $display("[%0t] result %0d mismatch: read_value exp %0d got %0d, %s",
                       $realtime, checked, want.rd, got.rd,
                       $sformatf("status exp %0d got %0d, count exp %0d got %0d",
                                 want.st, got.st, want.cnt, got.cnt));
            end
            mism++;
          end
        end
      end
      mismatches_o <= mism;
      pending_o <= expected_q.size();
      list_len_o <= len;
      checked_o <= checked;
      full_seen_o <= full_seen;
      range_seen_o <= range_seen;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// testbench top: clock, reset, list operation stimulus and verdict
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap        = 64;
  localparam int ItemsTotal = 1275;
  localparam int Limit      = 400000;

  logic clk;
  logic rst_n;
  logic calm;
  int   cycles;
  int   sent;
  int   hold;

  int mismatches;
  int pending;
  int list_len;
  int checked;
  int full_seen;
  int range_seen;

  ilid_req_if req_w ();
  ilid_rsp_if rsp_w ();

  indexed_list_insert_delete #(
    .CAPACITY(Cap)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_w),
    .rsp_o (rsp_w)
  );

  ilid_list_checker #(
    .Cap(Cap)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_w       (req_w),
    .rsp_w       (rsp_w),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .list_len_o  (list_len),
    .checked_o   (checked),
    .full_seen_o (full_seen),
    .range_seen_o(range_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (hold > 0) begin
      rsp_w.ready <= 1'b0;
      hold <= hold - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rsp_w.ready <= 1'b0;
      hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      rsp_w.ready <= 1'b1;
    end
  end

  task automatic put_word(input logic [ilid_pkg::OpW-1:0] op, input ilid_pkg::word_t val,
                          input int idx);
    req_w.valid <= 1'b1;
    req_w.op <= op;
    req_w.value <= val;
    req_w.index <= idx[6:0];
    do @(posedge clk); while (!req_w.ready);
    sent++;
  endtask

  task automatic gap(input int n);
    req_w.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic ilid_pkg::word_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ilid_pkg::OpW-1:0] pick_op(input int mode);
    int r;
    int unsigned code;
    r = $urandom_range(0, 99);
    if (r >= 97) return ilid_pkg::OP_CLEAR;
    if (r >= 93) begin
      code = ilid_pkg::OP_CLEAR + $urandom_range(1, 3);
      return code[ilid_pkg::OpW-1:0];
    end
    case (mode)
      0: begin
        if (r < 50) return ilid_pkg::OP_APPEND;
        if (r < 80) return ilid_pkg::OP_INSERT;
        if (r < 88) return ilid_pkg::OP_GET;
        return ilid_pkg::OP_DELETE;
      end
      1: begin
        if (r < 55) return ilid_pkg::OP_DELETE;
        if (r < 80) return ilid_pkg::OP_GET;
        if (r < 87) return ilid_pkg::OP_APPEND;
        return ilid_pkg::OP_INSERT;
      end
      default: begin
        if (r < 23) return ilid_pkg::OP_APPEND;
        if (r < 46) return ilid_pkg::OP_INSERT;
        if (r < 69) return ilid_pkg::OP_DELETE;
        return ilid_pkg::OP_GET;
      end
    endcase
  endfunction

  function automatic int pick_index(input logic [ilid_pkg::OpW-1:0] op, input int len);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, Cap);
    case (op)
      ilid_pkg::OP_INSERT: begin
        if (r == 1) return len;
        if (r == 2) return (len < Cap) ? len + 1 : Cap;
        return $urandom_range(0, len);
      end
      ilid_pkg::OP_DELETE, ilid_pkg::OP_GET: begin
        if (len == 0) return $urandom_range(0, Cap);
        if (r == 1) return len - 1;
        if (r == 2) return len;
        return $urandom_range(0, len - 1);
      end
      default: return $urandom_range(0, Cap);
    endcase
  endfunction

  initial begin
    int mode;
    int burst;
    int len;
    logic [ilid_pkg::OpW-1:0] op;
    req_w.valid = 1'b0;
    req_w.op = ilid_pkg::OP_CLEAR;
    req_w.value = '0;
    req_w.index = '0;
    rsp_w.ready = 1'b0;
    rst_n = 1'b0;
    calm = 1'b1;
    cycles = 0;
    sent = 0;
    hold = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, extremes, ends and out of range positions
    put_word(ilid_pkg::OP_GET, -1, 0);
    put_word(ilid_pkg::OP_DELETE, 0, 0);
    put_word(ilid_pkg::OP_INSERT, 1, 1);
    put_word(ilid_pkg::OP_INSERT, 32'sh8000_0000, 0);
    put_word(ilid_pkg::OP_APPEND, 32'sh7fff_ffff, 64);
    put_word(ilid_pkg::OP_APPEND, -1, 0);
    put_word(ilid_pkg::OP_APPEND, 0, 0);
    put_word(ilid_pkg::OP_INSERT, 32'sh5555_5555, 4);
    put_word(ilid_pkg::OP_INSERT, 32'shaaaa_aaaa, 1);
    put_word(ilid_pkg::OP_INSERT, 7, 7);
    put_word(ilid_pkg::OP_GET, 0, 0);
    put_word(ilid_pkg::OP_GET, 0, 4);
    put_word(ilid_pkg::OP_GET, 0, 5);
    put_word(ilid_pkg::OP_GET, 0, 64);
    put_word(ilid_pkg::OP_DELETE, 0, 4);
    put_word(ilid_pkg::OP_DELETE, 0, 0);
    put_word(ilid_pkg::OP_DELETE, 0, 3);
    put_word(ilid_pkg::OP_CLEAR + 3'd1, -1, 1);
    put_word(ilid_pkg::OP_CLEAR + 3'd2, 0, 64);
    put_word(ilid_pkg::OP_CLEAR + 3'd3, -1, 127);
    put_word(ilid_pkg::OP_CLEAR, 0, 0);
    put_word(ilid_pkg::OP_GET, 0, 0);
    put_word(ilid_pkg::OP_APPEND, 1, 0);
    put_word(ilid_pkg::OP_DELETE, 0, 0);
    put_word(ilid_pkg::OP_INSERT, -1, 0);

    while (sent < ItemsTotal) begin
      mode = $urandom_range(0, 3);
      burst = $urandom_range(8, 80);
      calm = ($urandom_range(0, 4) == 0);
      if (mode == 3) begin
        // reload: clear then mostly appends and inserts
        put_word(ilid_pkg::OP_CLEAR, pick_value(), $urandom_range(0, Cap));
        mode = 0;
      end
      repeat (burst) begin
        len = list_len;
        op = pick_op(mode);
        if (!calm && $urandom_range(0, 3) == 0) begin
          gap(($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
        end
        put_word(op, pick_value(), pick_index(op, len));
      end
    end
    req_w.valid <= 1'b0;
    calm = 1'b1;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d list operations sent, %0d result words checked, %0d mismatches",
             sent, checked, mismatches);
    $display("error results seen: %0d list full, %0d index out of range",
             full_seen, range_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
